@@ src/ptc_pkg.sv @@
// Shared types, constants and helpers for the pressure/temperature compensation block.
// No dependencies.
package ptc_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam int RAW_W  = 20;
  localparam int WORD_W = 32;
  localparam int ADDR_W = 5;
  localparam int BUS_W  = 64;

  localparam logic [1:0] REG_TEMP  = 2'd0;
  localparam logic [1:0] REG_PLOW  = 2'd1;
  localparam logic [1:0] REG_PHIGH = 2'd2;
  localparam logic [1:0] REG_P9    = 2'd3;

  localparam logic [63:0] FINE_OFS  = 64'd128000;
  localparam logic [63:0] P_BASE    = 64'd1048576;
  localparam logic [63:0] DIV_SCALE = 64'd3125;
  localparam logic [63:0] W1_BIAS   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] T_ROUND   = 32'd128;

  typedef struct packed {
    logic [31:0]      fine;
    logic [31:0]      temp;
    logic [RAW_W-1:0] raw_p;
  } item_t;

  function automatic logic [63:0] sext16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

endpackage

@@ src/ptc_mul64.sv @@
// Two-stage pipelined multiplier giving the low 64 bits of a 64 x 64 product.
// Depends on nothing.
module ptc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
      p  <= ll + {lh + hl, 32'd0};
    end
  end
endmodule

@@ src/ptc_fifo.sv @@
// Short word queue between the front (temperature) and back (pressure) parts.
// Depends on ptc_pkg.
module ptc_fifo
  import ptc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif
endmodule

@@ src/ptc_front.sv @@
// Front part: accepts raw readings and works out fine temperature and centi-degrees.
// Depends on ptc_pkg.
module ptc_front
  import ptc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_temperature,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [47:0]      temp_coeffs,
  input  logic             q_full,
  output logic             push,
  output item_t            item
);
  logic [31:0] t1, t2, t3;
  logic [31:0] a_in, d_in;
  logic        en;
  logic [4:0]  vld;
  logic [31:0] a1, d1, pa, dd, v1, m, fine3, fine4, temp4;
  logic [31:0] dd_sh, fine5;
  logic [RAW_W-1:0] rp1, rp2, rp3, rp4, rp5;

  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
  assign t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};

  assign a_in  = {15'd0, raw_temperature[19:3]} - {t1[30:0], 1'b0};
  assign d_in  = {16'd0, raw_temperature[19:4]} - t1;
  assign dd_sh = 32'($signed(dd) >>> 12);
  assign fine5 = {fine3[29:0], 2'b00} + fine3;

  assign en       = !vld[4] || !q_full;
  assign in_ready = en;
  assign push     = vld[4] && !q_full;
  assign item     = '{fine: fine4, temp: temp4, raw_p: rp5};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a_in;
      d1    <= d_in;
      rp1   <= raw_pressure;
      pa    <= a1 * t2;
      dd    <= d1 * d1;
      rp2   <= rp1;
      v1    <= 32'($signed(pa) >>> 11);
      m     <= dd_sh * t3;
      rp3   <= rp2;
      fine3 <= v1 + 32'($signed(m) >>> 14);
      rp4   <= rp3;
      rp5   <= rp4;
      fine4 <= fine3;
      temp4 <= 32'($signed(fine5 + T_ROUND) >>> 8);
    end
  end
endmodule

@@ src/ptc_div.sv @@
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
// Depends on nothing.
module ptc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  logic [31:0] in_temp,
  output logic        out_valid,
  output logic [63:0] quot,
  output logic        nonzero,
  output logic [31:0] out_temp
);
  logic [63:0] rem  [65];
  logic [63:0] qn   [65];
  logic [63:0] dv   [65];
  logic        neg  [65];
  logic        nz   [65];
  logic [31:0] tp   [65];
  logic [64:0] vld;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      qn[0]  <= num[63] ? 64'd0 - num : num;
      dv[0]  <= den[63] ? 64'd0 - den : den;
      neg[0] <= num[63] ^ den[63];
      nz[0]  <= (den != 64'd0);
      tp[0]  <= in_temp;
      quot     <= neg[64] ? 64'd0 - qn[64] : qn[64];
      nonzero  <= nz[64];
      out_temp <= tp[64];
    end
  end

  for (genvar k = 0; k < 64; k++) begin : g_step
    logic [64:0] trial;
    assign trial = {rem[k], qn[k][63]} - {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[64]) begin
          rem[k+1] <= trial[63:0];
        end else begin
          rem[k+1] <= {rem[k][62:0], qn[k][63]};
        end
        qn[k+1]  <= {qn[k][62:0], !trial[64]};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
        nz[k+1]  <= nz[k];
        tp[k+1]  <= tp[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[63:0], in_valid};
      out_valid <= vld[64];
    end
  end
endmodule

@@ src/ptc_back.sv @@
// Back part: 64-bit pressure compensation pipeline and the output register.
// Depends on ptc_pkg, ptc_mul64, ptc_div.
module ptc_back
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        pop,
  input  logic [63:0] plow,
  input  logic [63:0] phigh,
  input  logic [15:0] p9w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_temp,
  output logic [31:0] out_pres,
  output logic        out_pvalid
);
  logic        en;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [9:1]  v;
  logic [63:0] x1, pz1, pz2, pz3, pz4, pz5, pz6;
  logic [31:0] tp1, tp2, tp3, tp4, tp5, tp6, tp7, tp8, tp9;
  logic [63:0] xx3, xp5_3, xp2_3, w2a5, w1a5;
  logic [63:0] xp5_4, xp2_4, xp5_5, xp2_5;
  logic [63:0] w2_6, t6, nm7, t7, w1r9, nr9;
  logic        dvld, dnz;
  logic [63:0] dq;
  logic [31:0] dtp;
  logic [63:0] ps_d, p9ps2, p8p2, e1r2;
  logic [63:0] q_h1, q_h2, ps_h1, ps_h2, q_i1, q_i2, e2_i1, e2_i2, sum_j, pres_k;
  logic [31:0] tp_h1, tp_h2, tp_i1, tp_i2, tp_j;
  logic [3:0]  vh;
  logic        vj;
  logic        nz_h1, nz_h2, nz_i1, nz_i2, nz_j;

  assign p1 = {48'd0, plow[15:0]};
  assign p2 = sext16(plow[31:16]);
  assign p3 = sext16(plow[47:32]);
  assign p4 = sext16(plow[63:48]);
  assign p5 = sext16(phigh[15:0]);
  assign p6 = sext16(phigh[31:16]);
  assign p7 = sext16(phigh[47:32]);
  assign p8 = sext16(phigh[63:48]);
  assign p9 = sext16(p9w);

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      vh <= '0;
      vj <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v  <= {v[8:1], !q_empty};
      vh <= {vh[2:0], dvld};
      vj <= vh[3];
      out_valid <= vj;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= {{32{q_item.fine[31]}}, q_item.fine} - FINE_OFS;
      pz1   <= P_BASE - {44'd0, q_item.raw_p};
      tp1   <= q_item.temp;
      pz2   <= pz1;   tp2 <= tp1;
      pz3   <= pz2;   tp3 <= tp2;
      xp5_4 <= xp5_3; xp2_4 <= xp2_3; pz4 <= pz3; tp4 <= tp3;
      xp5_5 <= xp5_4; xp2_5 <= xp2_4; pz5 <= pz4; tp5 <= tp4;
      w2_6  <= w2a5 + {xp5_5[46:0], 17'd0} + {p4[28:0], 35'd0};
      t6    <= W1_BIAS + 64'($signed(w1a5) >>> 8) + {xp2_5[51:0], 12'd0};
      pz6   <= pz5;   tp6 <= tp5;
      nm7   <= {pz6[32:0], 31'd0} - w2_6;
      t7    <= t6;    tp7 <= tp6;
      tp8   <= tp7;
      tp9   <= tp8;
      q_h1  <= dq;    ps_h1 <= ps_d;  tp_h1 <= dtp;   nz_h1 <= dnz;
      q_h2  <= q_h1;  ps_h2 <= ps_h1; tp_h2 <= tp_h1; nz_h2 <= nz_h1;
      q_i1  <= q_h2;  e2_i1 <= 64'($signed(p8p2) >>> 19);
      tp_i1 <= tp_h2; nz_i1 <= nz_h2;
      q_i2  <= q_i1;  e2_i2 <= e2_i1; tp_i2 <= tp_i1; nz_i2 <= nz_i1;
      sum_j <= q_i2 + 64'($signed(e1r2) >>> 25) + e2_i2;
      tp_j  <= tp_i2; nz_j <= nz_i2;
      out_temp   <= tp_j;
      out_pres   <= nz_j ? pres_k[31:0] : 32'd0;
      out_pvalid <= nz_j;
    end
  end

  assign ps_d   = 64'($signed(dq) >>> 13);
  assign pres_k = 64'($signed(sum_j) >>> 8) + {p7[59:0], 4'd0};

  ptc_mul64 u_mul_xx  (.clk, .en, .a(x1), .b(x1), .p(xx3));
  ptc_mul64 u_mul_xp5 (.clk, .en, .a(x1), .b(p5), .p(xp5_3));
  ptc_mul64 u_mul_xp2 (.clk, .en, .a(x1), .b(p2), .p(xp2_3));
  ptc_mul64 u_mul_w2a (.clk, .en, .a(xx3), .b(p6), .p(w2a5));
  ptc_mul64 u_mul_w1a (.clk, .en, .a(xx3), .b(p3), .p(w1a5));
  ptc_mul64 u_mul_w1  (.clk, .en, .a(t7), .b(p1), .p(w1r9));
  ptc_mul64 u_mul_num (.clk, .en, .a(nm7), .b(DIV_SCALE), .p(nr9));
  ptc_mul64 u_mul_p9  (.clk, .en, .a(p9), .b(ps_d), .p(p9ps2));
  ptc_mul64 u_mul_p8  (.clk, .en, .a(p8), .b(dq), .p(p8p2));
  ptc_mul64 u_mul_e1  (.clk, .en, .a(p9ps2), .b(ps_h2), .p(e1r2));

  ptc_div u_div (
    .clk,
    .rst,
    .en,
    .in_valid  (v[9]),
    .num       (nr9),
    .den       (64'($signed(w1r9) >>> 33)),
    .in_temp   (tp9),
    .out_valid (dvld),
    .quot      (dq),
    .nonzero   (dnz),
    .out_temp  (dtp)
  );
endmodule

@@ src/pressure_temperature_compensation_top.sv @@
// Throughput: one word per cycle; the 64-stage divider and the 64-bit multipliers are
// fully pipelined, the back stalls as a whole only while the output word is not taken.
// Reset (rst, synchronous, active high) clears the queue, all valid flags and the
// calibration registers; no clearing pass is needed.
module pressure_temperature_compensation_top
  import ptc_pkg::*;
#(
  parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,   // raw_temperature, raw_pressure
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // temperature_centi, pressure_q24_8
  output logic [0:0]        m_tuser,   // pressure_valid
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [BUS_W-1:0]  pwdata,
  output logic [BUS_W-1:0]  prdata,
  output logic              pready
);
  logic [47:0] temp_coeffs;
  logic [63:0] pressure_coeffs_low;
  logic [63:0] pressure_coeffs_high;
  logic [15:0] pressure_coeff_nine;
  logic [1:0]  reg_idx;
  logic        wr_en;
  logic        push, pop, q_full, q_empty;
  item_t       f_item, q_item;
  logic [31:0] o_temp, o_pres;
  logic        o_pvalid;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs          <= '0;
      pressure_coeffs_low  <= '0;
      pressure_coeffs_high <= '0;
      pressure_coeff_nine  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEMP:  temp_coeffs          <= pwdata[47:0];
        REG_PLOW:  pressure_coeffs_low  <= pwdata;
        REG_PHIGH: pressure_coeffs_high <= pwdata;
        REG_P9:    pressure_coeff_nine  <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMP:  prdata = {16'd0, temp_coeffs};
      REG_PLOW:  prdata = pressure_coeffs_low;
      REG_PHIGH: prdata = pressure_coeffs_high;
      REG_P9:    prdata = {48'd0, pressure_coeff_nine};
      default:   prdata = '0;
    endcase
  end

  ptc_front u_front (
    .clk,
    .rst,
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .raw_temperature (s_tdata[19:0]),
    .raw_pressure    (s_tdata[39:20]),
    .temp_coeffs     (temp_coeffs),
    .q_full          (q_full),
    .push            (push),
    .item            (f_item)
  );

  ptc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk,
    .rst,
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  ptc_back u_back (
    .clk,
    .rst,
    .q_empty    (q_empty),
    .q_item     (q_item),
    .pop        (pop),
    .plow       (pressure_coeffs_low),
    .phigh      (pressure_coeffs_high),
    .p9w        (pressure_coeff_nine),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_temp   (o_temp),
    .out_pres   (o_pres),
    .out_pvalid (o_pvalid)
  );

  assign m_tdata = {o_pres, o_temp};
  assign m_tuser = o_pvalid;
endmodule
